// ----- design/ebps_pkg.sv -----
package ebps_pkg;

  // request codes
  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_ENCODER = 3'd1,
    REQ_BUTTON  = 3'd2,
    REQ_PEDAL   = 3'd3,
    REQ_READ    = 3'd4
  } req_type_e;

  localparam int unsigned IdleW    = 7;
  localparam int unsigned AngleW   = 4;
  localparam int unsigned LevelW   = 16;
  localparam int unsigned StatusW  = 16;
  localparam int unsigned DataW    = 32;

  // read word map: switch pairs first, then pedal pairs
  localparam int unsigned SwWords  = 3;
  localparam int unsigned PdWords  = 3;
  localparam int unsigned PadSlots = 6;

  typedef logic [StatusW-1:0] status_t;

  // registered request, shared by both banks
  typedef struct packed {
    logic                     valid;
    logic [2:0]               req_type;
    logic [2:0]               unit_index;
    logic                     switch_pressed;
    logic signed [AngleW-1:0] turn_delta;
    logic [LevelW-1:0]        pedal_level;
    logic [2:0]               reg_select;
  } req_t;

endpackage

// ----- design/ebps_switch_bank.sv -----
module ebps_switch_bank #(
  parameter int unsigned ENCODER_COUNT = 5,
  parameter int unsigned IDLE_LIMIT    = 127
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ebps_pkg::req_t                     req_i,
  output ebps_pkg::status_t [ENCODER_COUNT:0] status_o
);
  import ebps_pkg::*;

  localparam int unsigned Slots = ENCODER_COUNT + 1;
  localparam logic [IdleW-1:0] IdleMax = IdleW'(IDLE_LIMIT);

  logic [Slots-1:0]             pressed_q, pressed_d;
  logic [Slots-1:0][IdleW-1:0]  idle_q, idle_d;

  logic tick;
  assign tick = req_i.valid && (req_i.req_type == REQ_TICK);

  for (genvar s = 0; s < Slots; s++) begin : g_slot
    logic hit;
    logic changed;
    logic turn;

    if (s < ENCODER_COUNT) begin : g_enc
      logic [AngleW-1:0] normal_q, normal_d;
      logic [AngleW-1:0] held_q, held_d;

      assign hit  = req_i.valid && (req_i.req_type == REQ_ENCODER)
                    && (req_i.unit_index == 3'(s));
      assign turn = hit && (req_i.turn_delta != '0);

      always_comb begin
        normal_d = normal_q;
        held_d   = held_q;
        if (turn) begin
          // angle chosen by the new pressed flag, wraps mod 16
          if (req_i.switch_pressed) begin
            held_d = held_q + unsigned'(req_i.turn_delta);
          end else begin
            normal_d = normal_q + unsigned'(req_i.turn_delta);
          end
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          normal_q <= '0;
          held_q   <= '0;
        end else begin
          normal_q <= normal_d;
          held_q   <= held_d;
        end
      end

      assign status_o[s] = {pressed_q[s], idle_q[s], held_q, normal_q};
    end else begin : g_btn
      assign hit  = req_i.valid && (req_i.req_type == REQ_BUTTON)
                    && (req_i.unit_index == '0);
      assign turn = 1'b0;
      assign status_o[s] = {pressed_q[s], idle_q[s], {(2*AngleW){1'b0}}};
    end

    assign changed = hit && (pressed_q[s] != req_i.switch_pressed);

    always_comb begin
      pressed_d[s] = pressed_q[s];
      idle_d[s]    = idle_q[s];
      if (changed || turn) begin
        pressed_d[s] = hit ? req_i.switch_pressed : pressed_q[s];
        idle_d[s]    = '0;
      end else if (tick && (idle_q[s] < IdleMax)) begin
        idle_d[s] = idle_q[s] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= '0;
      idle_q    <= '0;
    end else begin
      pressed_q <= pressed_d;
      idle_q    <= idle_d;
    end
  end

endmodule

// ----- design/ebps_pedal_bank.sv -----
module ebps_pedal_bank #(
  parameter int unsigned PEDAL_COUNT = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ebps_pkg::req_t                      req_i,
  output ebps_pkg::status_t [PEDAL_COUNT-1:0] status_o
);
  import ebps_pkg::*;

  logic [PEDAL_COUNT-1:0][LevelW-1:0] level_q, level_d;

  always_comb begin
    level_d = level_q;
    for (int p = 0; p < PEDAL_COUNT; p++) begin
      if (req_i.valid && (req_i.req_type == REQ_PEDAL) && (req_i.unit_index == 3'(p))) begin
        level_d[p] = req_i.pedal_level;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  assign status_o = level_q;

endmodule

// ----- design/encoder_button_pedal_status_regs_top.sv -----
// Status registers for up to five rotary encoders with push switches, one
// tact button and up to six pedals. A request is taken on every clock edge
// with start_i high (busy_o never rises), so one request per cycle is
// sustained. Each request goes through an input register, then updates the
// switch and pedal banks while a register read is muxed into the result
// register: a read result shows on read_data_o with done_o as it leaves
// the result register, for one cycle only. The receiver cannot stall, so it
// must capture read_data_o whenever done_o is high. Requests act in order,
// so a read sees every update transferred before it. Ticks bump each switch
// idle count up to IDLE_LIMIT; a press change or encoder turn clears it. Read
// words 0..2 hold switch pairs (bit 15 pressed, 14:8 idle, 7:4 held angle,
// 3:0 normal angle), words 3..5 pedal pairs; a missing unit and words 6..7
// read zero. Requests of unknown type or with an out-of-range unit do nothing.
module encoder_button_pedal_status_regs_top #(
  parameter int unsigned ENCODER_COUNT = 5,
  parameter int unsigned PEDAL_COUNT   = 6,
  parameter int unsigned IDLE_LIMIT    = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [2:0]  unit_index_i,
  input  logic        switch_pressed_i,
  input  logic signed [3:0] turn_delta_i,
  input  logic [15:0] pedal_level_i,
  input  logic [2:0]  reg_select_i,
  output logic        done_o,
  output logic [31:0] read_data_o
);
  import ebps_pkg::*;

  localparam int unsigned Slots = ENCODER_COUNT + 1;

  // input register
  req_t req_q, req_d;

  always_comb begin
    req_d.valid          = start_i && !busy_o;
    req_d.req_type       = req_type_i;
    req_d.unit_index     = unit_index_i;
    req_d.switch_pressed = switch_pressed_i;
    req_d.turn_delta     = turn_delta_i;
    req_d.pedal_level    = pedal_level_i;
    req_d.reg_select     = reg_select_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q <= req_d;
    end
  end

  assign busy_o = 1'b0;

  // state banks: updated by req_q, status reflects state before that update
  status_t [ENCODER_COUNT:0]  sw_status;
  status_t [PEDAL_COUNT-1:0]  pd_status;

  ebps_switch_bank #(
    .ENCODER_COUNT (ENCODER_COUNT),
    .IDLE_LIMIT    (IDLE_LIMIT)
  ) u_switch_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_q),
    .status_o (sw_status)
  );

  ebps_pedal_bank #(
    .PEDAL_COUNT (PEDAL_COUNT)
  ) u_pedal_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_q),
    .status_o (pd_status)
  );

  // pad to the six units the read map can address; missing units read zero
  status_t [PadSlots-1:0] sw_pad;
  status_t [PadSlots-1:0] pd_pad;

  always_comb begin
    for (int i = 0; i < PadSlots; i++) begin
      sw_pad[i] = (i < Slots)       ? sw_status[i] : '0;
      pd_pad[i] = (i < PEDAL_COUNT) ? pd_status[i] : '0;
    end
  end

  // result register
  logic             done_q, done_d;
  logic [DataW-1:0] rdata_q, rdata_d;

  always_comb begin
    done_d  = req_q.valid && (req_q.req_type == REQ_READ);
    rdata_d = '0;
    for (int r = 0; r < SwWords; r++) begin
      if (req_q.reg_select == 3'(r)) begin
        rdata_d = {sw_pad[2*r+1], sw_pad[2*r]};
      end
    end
    for (int r = 0; r < PdWords; r++) begin
      if (req_q.reg_select == 3'(SwWords + r)) begin
        rdata_d = {pd_pad[2*r+1], pd_pad[2*r]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      rdata_q <= rdata_d;
    end
  end

  assign done_o      = done_q;
  assign read_data_o = rdata_q;

  // a read request always yields exactly one result, in the cycle after
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_q.valid && (req_q.req_type == REQ_READ) |=> done_o)
    else $error("read request produced no result");

  // nothing but a read yields a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_q.valid && (req_q.req_type == REQ_READ)) |=> !done_o)
    else $error("result without read request");

  // unused read words return zero
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_q.valid && (req_q.req_type == REQ_READ)
      && ((req_q.reg_select == 3'd6) || (req_q.reg_select == 3'd7))
      |=> (read_data_o == '0))
    else $error("unused read word not zero");

  // a transferred request reaches the input register
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> req_q.valid)
    else $error("transfer lost");

endmodule
